@@ sv/e80dc_pkg.sv @@
// ============================================================================
// e80dc_pkg
// Shared types and constants of the extended80 / binary64 format converter.
// ============================================================================
`default_nettype none

package e80dc_pkg;

	// extended format exponent limits
	localparam logic [14:0] EXT_EXP_MAX  = 15'h7fff;
	// exponent rebias between extended and double (16383 - 1023)
	localparam logic [14:0] BIAS_DIFF    = 15'd15360;
	// rebias plus the 12 bit offset of a 52 bit fraction inside 64 bits
	localparam logic [14:0] DEN_BASE     = 15'd15372;
	// extended exponents at or below this flush to zero in a double
	localparam logic [14:0] E2D_ZERO_MAX = 15'd15308;
	// extended exponents at or above this overflow a double
	localparam logic [14:0] E2D_OVF_MIN  = 15'd17407;

	localparam logic [10:0] DBL_EXP_MAX  = 11'h7ff;
	localparam logic [63:0] DBL_INF      = 64'h7ff0_0000_0000_0000;
	localparam logic [63:0] DBL_QNAN     = 64'h7ff8_0000_0000_0000;
	localparam logic [63:0] EXT_INT_BIT  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] EXT_QNAN     = 64'hc000_0000_0000_0000;

	// conversion direction
	typedef enum logic {
		MODE_E2D = 1'b0,
		MODE_D2E = 1'b1
	} mode_t;

	// operand class found by the decode stage
	typedef enum logic [2:0] {
		CLS_ZERO   = 3'd0,
		CLS_INF    = 3'd1,
		CLS_QNAN   = 3'd2,
		CLS_SHIFT  = 3'd3,
		CLS_NORMAL = 3'd4
	} cls_t;

	// operand as it travels down the pipeline
	typedef struct packed {
		mode_t       mode;
		logic        sign;
		cls_t        cls;
		logic [5:0]  shamt;
		logic [14:0] exp;
		logic [63:0] sig;
	} op_t;

endpackage

`default_nettype wire

@@ sv/e80dc_in_if.sv @@
// ============================================================================
// e80dc_in_if
// Operand channel of the converter: valid/ready handshake plus payload.
// ============================================================================
`default_nettype none

interface e80dc_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] ext_sign_exp;
	logic [63:0] ext_mantissa;
	logic [63:0] dbl_in;

	modport source (output valid, mode, ext_sign_exp, ext_mantissa, dbl_in, input ready);
	modport sink   (input valid, mode, ext_sign_exp, ext_mantissa, dbl_in, output ready);
endinterface

`default_nettype wire

@@ sv/e80dc_out_if.sv @@
// ============================================================================
// e80dc_out_if
// Result channel of the converter: valid/ready handshake plus payload.
// ============================================================================
`default_nettype none

interface e80dc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] dbl_out;
	logic [15:0] ext_sign_exp_out;
	logic [63:0] ext_mantissa_out;

	modport source (output valid, dbl_out, ext_sign_exp_out, ext_mantissa_out, input ready);
	modport sink   (input valid, dbl_out, ext_sign_exp_out, ext_mantissa_out, output ready);
endinterface

`default_nettype wire

@@ sv/ext80_double_format_convert_top.sv @@
// ============================================================================
// ext80_double_format_convert_top
// Converter between the x87 80-bit extended format and IEEE binary64.
// ============================================================================
// One operand beat is taken every cycle unless the full pipeline is stalled:
// stage 1 decodes the operand and counts leading zeros, stage 2 runs the
// denormal shifter, stage 3 packs the result into the output register.
// A stalled output holds the pipeline; ready propagates back through the
// stages, so bubbles are squeezed out and a full pipeline holds three beats.
// mode 0 converts extended to double with truncation (denormal extended
// inputs flush to signed zero, NaNs become the canonical quiet NaN);
// mode 1 converts double to extended exactly. The fields of the direction
// not selected read as zero.
// ============================================================================
`default_nettype none

module ext80_double_format_convert_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	e80dc_in_if.sink    din,
	e80dc_out_if.source dout
);
	import e80dc_pkg::*;

	logic v1;
	logic v2;
	logic rdy1;
	logic rdy2;
	op_t  op1;
	op_t  op2;

	// stage 1: classify and rebias
	e80dc_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (din.valid),
		.in_ready    (din.ready),
		.in_mode     (din.mode),
		.in_sign_exp (din.ext_sign_exp),
		.in_mantissa (din.ext_mantissa),
		.in_dbl      (din.dbl_in),
		.out_valid   (v1),
		.out_ready   (rdy1),
		.out_op      (op1)
	);

	// stage 2: denormal shift
	e80dc_shift u_shift (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (rdy1),
		.in_op     (op1),
		.out_valid (v2),
		.out_ready (rdy2),
		.out_op    (op2)
	);

	// stage 3: result assembly
	e80dc_pack u_pack (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (v2),
		.in_ready         (rdy2),
		.in_op            (op2),
		.out_valid        (dout.valid),
		.out_ready        (dout.ready),
		.dbl_out          (dout.dbl_out),
		.ext_sign_exp_out (dout.ext_sign_exp_out),
		.ext_mantissa_out (dout.ext_mantissa_out)
	);

`ifndef ASSERT_OFF
	// input backpressure only when the whole pipeline is full and stalled
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> (v1 && v2 && dout.valid && !dout.ready))
		else $error("top: input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

@@ sv/e80dc_decode.sv @@
// ============================================================================
// e80dc_decode
// Stage 1: classifies the operand, rebiases the exponent and finds the
// shift amount (leading-zero count for a double denormal).
// ============================================================================
`default_nettype none

module e80dc_decode (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            in_mode,
	input  wire logic [15:0]     in_sign_exp,
	input  wire logic [63:0]     in_mantissa,
	input  wire logic [63:0]     in_dbl,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output e80dc_pkg::op_t       out_op
);
	import e80dc_pkg::*;

	// leading zeros of a nonzero word, six halving steps
	function automatic logic [5:0] lead_zeros(input logic [63:0] v);
		logic [63:0] t;
		logic [5:0]  n;
		begin
			t = v;
			n = '0;
			if (t[63:32] == '0) begin
				n[5] = 1'b1;
				t = {t[31:0], 32'b0};
			end
			if (t[63:48] == '0) begin
				n[4] = 1'b1;
				t = {t[47:0], 16'b0};
			end
			if (t[63:56] == '0) begin
				n[3] = 1'b1;
				t = {t[55:0], 8'b0};
			end
			if (t[63:60] == '0) begin
				n[2] = 1'b1;
				t = {t[59:0], 4'b0};
			end
			if (t[63:62] == '0) begin
				n[1] = 1'b1;
				t = {t[61:0], 2'b0};
			end
			if (!t[63]) begin
				n[0] = 1'b1;
			end
			return n;
		end
	endfunction

	logic        v_s1;
	op_t         op_s1;
	op_t         op_nx;
	logic [14:0] e80;
	logic [10:0] e64;
	logic [51:0] f64;
	logic [14:0] e2d_den_sh;
	logic [14:0] e2d_norm_exp;
	logic [5:0]  d2e_lz;

	assign e80          = in_sign_exp[14:0];
	assign e64          = in_dbl[62:52];
	assign f64          = in_dbl[51:0];
	assign e2d_den_sh   = DEN_BASE - e80;
	assign e2d_norm_exp = e80 - BIAS_DIFF;
	assign d2e_lz       = lead_zeros({12'b0, f64});

	// operand classification
	always_comb begin
		op_nx       = '0;
		op_nx.mode  = mode_t'(in_mode);
		op_nx.cls   = CLS_ZERO;
		if (op_nx.mode == MODE_E2D) begin
			op_nx.sign = in_sign_exp[15];
			op_nx.sig  = in_mantissa;
			if (e80 == '0) begin
				op_nx.cls = CLS_ZERO;
			end else if (e80 == EXT_EXP_MAX) begin
				op_nx.cls = (in_mantissa == EXT_INT_BIT) ? CLS_INF : CLS_QNAN;
			end else if (e80 <= E2D_ZERO_MAX) begin
				op_nx.cls = CLS_ZERO;
			end else if (e80 <= BIAS_DIFF) begin
				op_nx.cls   = CLS_SHIFT;
				op_nx.shamt = e2d_den_sh[5:0];
			end else if (e80 >= E2D_OVF_MIN) begin
				op_nx.cls = CLS_INF;
			end else begin
				op_nx.cls = CLS_NORMAL;
				op_nx.exp = e2d_norm_exp;
			end
		end else begin
			op_nx.sign = in_dbl[63];
			if (e64 == '0) begin
				if (f64 == '0) begin
					op_nx.cls = CLS_ZERO;
				end else begin
					op_nx.cls   = CLS_SHIFT;
					op_nx.shamt = d2e_lz;
					op_nx.exp   = DEN_BASE - {9'b0, d2e_lz};
					op_nx.sig   = {12'b0, f64};
				end
			end else if (e64 == DBL_EXP_MAX) begin
				op_nx.cls = (f64 == '0) ? CLS_INF : CLS_QNAN;
				op_nx.exp = EXT_EXP_MAX;
			end else begin
				op_nx.cls = CLS_NORMAL;
				op_nx.exp = {4'b0, e64} + BIAS_DIFF;
				op_nx.sig = {1'b1, f64, 11'b0};
			end
		end
	end

	// stage register
	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= op_nx;
		end
	end

	assign out_valid = v_s1;
	assign out_op    = op_s1;

endmodule

`default_nettype wire

@@ sv/e80dc_shift.sv @@
// ============================================================================
// e80dc_shift
// Stage 2: right shift into a double denormal, or left shift that
// normalizes a double denormal into the extended format.
// ============================================================================
`default_nettype none

module e80dc_shift (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire e80dc_pkg::op_t  in_op,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output e80dc_pkg::op_t       out_op
);
	import e80dc_pkg::*;

	logic v_s2;
	op_t  op_s2;
	op_t  op_nx;

	// significand shift, only for denormal cases
	always_comb begin
		op_nx = in_op;
		if (in_op.cls == CLS_SHIFT) begin
			if (in_op.mode == MODE_E2D) begin
				op_nx.sig = in_op.sig >> in_op.shamt;
			end else begin
				op_nx.sig = in_op.sig << in_op.shamt;
			end
		end
	end

	// stage register
	assign in_ready = !v_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s2 <= op_nx;
		end
	end

	assign out_valid = v_s2;
	assign out_op    = op_s2;

endmodule

`default_nettype wire

@@ sv/e80dc_pack.sv @@
// ============================================================================
// e80dc_pack
// Stage 3: assembles the result fields and holds them in the output
// register until the beat is taken.
// ============================================================================
`default_nettype none

module e80dc_pack (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire e80dc_pkg::op_t  in_op,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [63:0]          dbl_out,
	output logic [15:0]          ext_sign_exp_out,
	output logic [63:0]          ext_mantissa_out
);
	import e80dc_pkg::*;

	logic        v_s3;
	mode_t       mode_s3;
	logic [63:0] dbl_s3;
	logic [15:0] se_s3;
	logic [63:0] mant_s3;
	logic [62:0] mag_nx;
	logic [63:0] dbl_nx;
	logic [15:0] se_nx;
	logic [63:0] mant_nx;

	// double magnitude by class
	always_comb begin
		unique case (in_op.cls)
			CLS_ZERO:   mag_nx = '0;
			CLS_INF:    mag_nx = DBL_INF[62:0];
			CLS_QNAN:   mag_nx = DBL_QNAN[62:0];
			CLS_SHIFT:  mag_nx = in_op.sig[62:0];
			CLS_NORMAL: mag_nx = {in_op.exp[10:0], in_op.sig[62:11]};
			default:    mag_nx = '0;
		endcase
	end

	// extended significand by class
	always_comb begin
		unique case (in_op.cls)
			CLS_ZERO:   mant_nx = '0;
			CLS_INF:    mant_nx = EXT_INT_BIT;
			CLS_QNAN:   mant_nx = EXT_QNAN;
			CLS_SHIFT:  mant_nx = in_op.sig;
			CLS_NORMAL: mant_nx = in_op.sig;
			default:    mant_nx = '0;
		endcase
	end

	// unused direction reads as zero
	always_comb begin
		if (in_op.mode == MODE_E2D) begin
			dbl_nx = {in_op.sign, mag_nx};
			se_nx  = '0;
		end else begin
			dbl_nx = '0;
			se_nx  = {in_op.sign, in_op.exp};
		end
	end

	// output register
	assign in_ready = !v_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s3 <= in_op.mode;
			dbl_s3  <= dbl_nx;
			se_s3   <= se_nx;
			mant_s3 <= (in_op.mode == MODE_E2D) ? '0 : mant_nx;
		end
	end

	assign out_valid        = v_s3;
	assign dbl_out          = dbl_s3;
	assign ext_sign_exp_out = se_s3;
	assign ext_mantissa_out = mant_s3;

`ifndef ASSERT_OFF
	// only the fields of the selected direction carry data
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ((mode_s3 == MODE_E2D) ? (se_s3 == '0 && mant_s3 == '0) : (dbl_s3 == '0)))
		else $error("e80dc_pack: unused result fields not zero");

	// a double with all-ones exponent is exactly infinity or the quiet nan
	a_dbl_special: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && mode_s3 == MODE_E2D && dbl_s3[62:52] == DBL_EXP_MAX)
		|-> (dbl_s3[51:0] == DBL_INF[51:0] || dbl_s3[51:0] == DBL_QNAN[51:0]))
		else $error("e80dc_pack: malformed double special value");

	// every nonzero extended result carries its integer bit
	a_ext_int_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && mode_s3 == MODE_D2E && se_s3[14:0] != '0) |-> mant_s3[63])
		else $error("e80dc_pack: extended result not normalized");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ============================================================================
// testbench
// Checks the extended80 / binary64 converter beat by beat against a predictor.
// A short directed table covers zeros, denormals, infinities, NaNs, the edges
// where a double underflows or overflows, and unnormals. Random operands
// follow, weighted toward those edges. Both channels idle at random, and the
// result side holds off long enough to stall the operand side.
// ============================================================================

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import e80dc_pkg::*;

	localparam int N_RANDOM = 1550;
	localparam int IDLE_PCT = 15;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] ext_se;
		logic [63:0] ext_man;
		logic [63:0] dbl;
	} conv_op_t;

	typedef struct packed {
		logic [63:0] dbl;
		logic [15:0] ext_se;
		logic [63:0] ext_man;
	} conv_result_t;

	typedef struct packed {
		conv_op_t     op;
		logic         typed;
		conv_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	e80dc_in_if  din();
	e80dc_out_if dout();

	ext80_double_format_convert_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	stim_row_t    stim_table[$];
	conv_result_t pending_results[$];
	conv_result_t held_result;
	bit           in_beat;
	int           beats_sent;
	int           fail_count;

	// no idling on either side in this window
	function automatic bit calm_window();
		return beats_sent >= 700 && beats_sent < 1000;
	endfunction

	// extended to double, truncating
	function automatic logic [63:0] narrow_to_double(logic [15:0] se, logic [63:0] man);
		int          rexp;
		logic [63:0] mag;
		rexp = int'(se[14:0]) - int'(BIAS_DIFF);
		if (se[14:0] == 15'd0) begin
			mag = '0;
		end else if (se[14:0] == EXT_EXP_MAX) begin
			mag = (man == EXT_INT_BIT) ? DBL_INF : DBL_QNAN;
		end else if (rexp <= -52) begin
			mag = '0;
		end else if (rexp <= 0) begin
			mag = man >> (12 - rexp);
		end else if (rexp >= int'(DBL_EXP_MAX)) begin
			mag = DBL_INF;
		end else begin
			mag = {1'b0, rexp[10:0], man[62:11]};
		end
		return {se[15], mag[62:0]};
	endfunction

	// double to extended, exact; denormals normalized
	function automatic conv_result_t widen_to_extended(logic [63:0] d);
		conv_result_t r;
		logic [63:0]  frac;
		int           lz;
		r = '0;
		frac = {12'd0, d[51:0]};
		if (d[62:52] == 11'd0) begin
			if (frac == 64'd0) begin
				r.ext_se = {d[63], 15'd0};
			end else begin
				lz = 0;
				while (!frac[63]) begin
					frac = frac << 1;
					lz++;
				end
				r.ext_se = {d[63], DEN_BASE - 15'(lz)};
				r.ext_man = frac;
			end
		end else if (d[62:52] == DBL_EXP_MAX) begin
			r.ext_se = {d[63], EXT_EXP_MAX};
			r.ext_man = (frac == 64'd0) ? EXT_INT_BIT : EXT_QNAN;
		end else begin
			r.ext_se = {d[63], 15'(d[62:52]) + BIAS_DIFF};
			r.ext_man = {1'b1, d[51:0], 11'd0};
		end
		return r;
	endfunction

	function automatic conv_result_t predict_conversion(conv_op_t op);
		conv_result_t r;
		if (op.mode == MODE_E2D) begin
			r = '0;
			r.dbl = narrow_to_double(op.ext_se, op.ext_man);
		end else begin
			r = widen_to_extended(op.dbl);
		end
		return r;
	endfunction

	function automatic stim_row_t tab_row(mode_t m, logic [15:0] se, logic [63:0] man,
			logic [63:0] d, logic typed, logic [63:0] r_dbl, logic [15:0] r_se,
			logic [63:0] r_man);
		stim_row_t row;
		row.op = '{m, se, man, d};
		row.typed = typed;
		row.res = '{r_dbl, r_se, r_man};
		return row;
	endfunction

	// random operand, weighted toward class and range edges
	function automatic conv_op_t random_operand();
		conv_op_t    op;
		logic [14:0] ex;
		op.mode = mode_t'($urandom_range(1));
		op.ext_se = 16'($urandom);
		op.ext_man = {$urandom, $urandom};
		op.dbl = {$urandom, $urandom};
		case ($urandom_range(9))
			0: ex = 15'd0;
			1: ex = EXT_EXP_MAX;
			2, 3: ex = 15'($urandom_range(15300, 15365));
			4: ex = 15'($urandom_range(17400, 17410));
			5, 6, 7: ex = 15'($urandom_range(15361, 17406));
			default: ex = 15'($urandom);
		endcase
		op.ext_se[14:0] = ex;
		case ($urandom_range(7))
			0: op.ext_man = EXT_INT_BIT;
			1: op.ext_man[63] = 1'b0;
			2: op.ext_man[63:62] = 2'b11;
			default: op.ext_man[63] = 1'b1;
		endcase
		case ($urandom_range(7))
			0: begin
				op.dbl[62:52] = 11'd0;
				op.dbl[51:0] = op.dbl[51:0] >> $urandom_range(51);
			end
			1: op.dbl[62:52] = DBL_EXP_MAX;
			2: begin
				op.dbl[62:52] = $urandom_range(1) ? DBL_EXP_MAX : 11'd0;
				op.dbl[51:0] = '0;
			end
			default: ;
		endcase
		return op;
	endfunction

	// handshake monitor and result checker
	always @(posedge clk) begin
		conv_result_t got;
		conv_result_t want;
		in_beat = din.valid && din.ready;
		if (arst_n) begin
			if (in_beat)
				pending_results.push_back(held_result);
			if (dout.valid && dout.ready) begin
				got = '{dout.dbl_out, dout.ext_sign_exp_out, dout.ext_mantissa_out};
				if (pending_results.size() == 0) begin
					$display("%0d ns: result beat with nothing expected, got %h %h %h",
						$time, got.dbl, got.ext_se, got.ext_man);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.dbl !== want.dbl) begin
						$display("%0d ns: dbl_out expected %h got %h",
							$time, want.dbl, got.dbl);
						fail_count++;
					end
					if (got.ext_se !== want.ext_se) begin
						$display("%0d ns: ext_sign_exp_out expected %h got %h",
							$time, want.ext_se, got.ext_se);
						fail_count++;
					end
					if (got.ext_man !== want.ext_man) begin
						$display("%0d ns: ext_mantissa_out expected %h got %h",
							$time, want.ext_man, got.ext_man);
						fail_count++;
					end
				end
			end
		end
	end

	// result side: random stalls plus two long hold-offs
	initial begin
		int hold_left;
		bit [1:0] holds_done;
		hold_left = 0;
		holds_done = '0;
		dout.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!holds_done[0] && beats_sent >= 300) begin
				hold_left = 80;
				holds_done[0] = 1'b1;
			end
			if (!holds_done[1] && beats_sent >= 1200) begin
				hold_left = 120;
				holds_done[1] = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				dout.ready <= 1'b0;
			end else begin
				dout.ready <= calm_window() || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// reset, operand stream and end of run
	initial begin
		conv_op_t op;
		int       k;
		int       n_total;
		arst_n = 1'b0;
		din.valid <= 1'b0;
		din.mode <= MODE_E2D;
		din.ext_sign_exp <= '0;
		din.ext_mantissa <= '0;
		din.dbl_in <= '0;
		held_result = '0;
		in_beat = 1'b0;
		beats_sent = 0;
		fail_count = 0;

		// extended to double
		stim_table.push_back(tab_row(MODE_E2D, 16'h0000, 64'h0, '1,
			1'b1, 64'h0, 16'h0, 64'h0));
		// negative denormal flushes to signed zero
		stim_table.push_back(tab_row(MODE_E2D, 16'h8000, '1, '0,
			1'b1, 64'h8000_0000_0000_0000, 16'h0, 64'h0));
		stim_table.push_back(tab_row(MODE_E2D, 16'h7fff, EXT_INT_BIT, '0,
			1'b1, DBL_INF, 16'h0, 64'h0));
		stim_table.push_back(tab_row(MODE_E2D, 16'hffff, EXT_INT_BIT, '0,
			1'b1, 64'hfff0_0000_0000_0000, 16'h0, 64'h0));
		stim_table.push_back(tab_row(MODE_E2D, 16'h7fff, EXT_QNAN, '0,
			1'b1, DBL_QNAN, 16'h0, 64'h0));
		// pseudo-infinity and pseudo-nan
		stim_table.push_back(tab_row(MODE_E2D, 16'h7fff, 64'h0, '0,
			1'b1, DBL_QNAN, 16'h0, 64'h0));
		stim_table.push_back(tab_row(MODE_E2D, 16'hffff, 64'h4000_0000_0000_0001, '0,
			1'b1, 64'hfff8_0000_0000_0000, 16'h0, 64'h0));
		// first overflowing exponent and largest normal
		stim_table.push_back(tab_row(MODE_E2D, 16'h43ff, EXT_INT_BIT, '0,
			1'b1, DBL_INF, 16'h0, 64'h0));
		stim_table.push_back(tab_row(MODE_E2D, 16'h43fe, '1, '0,
			1'b1, 64'h7fef_ffff_ffff_ffff, 16'h0, 64'h0));
		// flush edge and deepest double denormal
		stim_table.push_back(tab_row(MODE_E2D, 16'h3bcc, '1, '0,
			1'b1, 64'h0, 16'h0, 64'h0));
		stim_table.push_back(tab_row(MODE_E2D, 16'h3bcd, '1, '0,
			1'b1, 64'h1, 16'h0, 64'h0));
		stim_table.push_back(tab_row(MODE_E2D, 16'h3c00, EXT_INT_BIT, '0,
			1'b1, 64'h0008_0000_0000_0000, 16'h0, 64'h0));
		stim_table.push_back(tab_row(MODE_E2D, 16'h3c01, EXT_INT_BIT, '0,
			1'b1, 64'h0010_0000_0000_0000, 16'h0, 64'h0));
		stim_table.push_back(tab_row(MODE_E2D, 16'h3fff, EXT_INT_BIT, '1,
			1'b1, 64'h3ff0_0000_0000_0000, 16'h0, 64'h0));
		// unnormals in both ranges, truncation
		stim_table.push_back(tab_row(MODE_E2D, 16'hbfff, 64'h800, '0,
			1'b0, '0, '0, '0));
		stim_table.push_back(tab_row(MODE_E2D, 16'h3c00, 64'h7fff_ffff_ffff_ffff, '0,
			1'b0, '0, '0, '0));
		stim_table.push_back(tab_row(MODE_E2D, 16'h3fff, '1, '0,
			1'b0, '0, '0, '0));
		// double to extended
		stim_table.push_back(tab_row(MODE_D2E, '1, '1, 64'h0,
			1'b1, 64'h0, 16'h0000, 64'h0));
		stim_table.push_back(tab_row(MODE_D2E, '0, '0, 64'h8000_0000_0000_0000,
			1'b1, 64'h0, 16'h8000, 64'h0));
		stim_table.push_back(tab_row(MODE_D2E, '0, '0, DBL_INF,
			1'b1, 64'h0, 16'h7fff, EXT_INT_BIT));
		stim_table.push_back(tab_row(MODE_D2E, '0, '0, 64'hfff0_0000_0000_0001,
			1'b1, 64'h0, 16'hffff, EXT_QNAN));
		// smallest and largest double denormal
		stim_table.push_back(tab_row(MODE_D2E, '0, '0, 64'h1,
			1'b1, 64'h0, 16'h3bcd, EXT_INT_BIT));
		stim_table.push_back(tab_row(MODE_D2E, '0, '0, 64'h000f_ffff_ffff_ffff,
			1'b0, '0, '0, '0));
		stim_table.push_back(tab_row(MODE_D2E, '0, '0, 64'h3ff0_0000_0000_0000,
			1'b1, 64'h0, 16'h3fff, EXT_INT_BIT));
		stim_table.push_back(tab_row(MODE_D2E, '0, '0, 64'hffef_ffff_ffff_ffff,
			1'b0, '0, '0, '0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		n_total = stim_table.size() + N_RANDOM;
		for (k = 0; k < n_total; k++) begin
			if (k < stim_table.size()) begin
				op = stim_table[k].op;
				held_result = stim_table[k].typed ? stim_table[k].res
					: predict_conversion(op);
			end else begin
				op = random_operand();
				held_result = predict_conversion(op);
			end
			while (!calm_window() && $urandom_range(99) < IDLE_PCT) begin
				din.valid <= 1'b0;
				@(negedge clk);
			end
			din.valid <= 1'b1;
			din.mode <= op.mode;
			din.ext_sign_exp <= op.ext_se;
			din.ext_mantissa <= op.ext_man;
			din.dbl_in <= op.dbl;
			@(negedge clk);
			while (!in_beat)
				@(negedge clk);
			beats_sent++;
		end
		din.valid <= 1'b0;

		// drain, then watch a few more cycles for stray beats
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
sv/e80dc_pkg.sv
sv/e80dc_in_if.sv
sv/e80dc_out_if.sv
sv/e80dc_decode.sv
sv/e80dc_shift.sv
sv/e80dc_pack.sv
sv/ext80_double_format_convert_top.sv
tb/testbench.sv
